### src/swe_pkg.sv
// Shared constants for the stack with edit operations: sizes, action codes,
// status codes and the packed stream widths.
// No dependencies.
package swe_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = 5;
  localparam int CAP_W   = 5;
  localparam int WORD_W  = 32;
  localparam int ACT_W   = 3;
  localparam int STAT_W  = 2;

  localparam int OUT_BITS = STAT_W + CNT_W + WORD_W + 3;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic [ACT_W-1:0] ACT_PUSH    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_POP     = 3'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DUP     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SWAP    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_REMOVE  = 3'd5;
  localparam logic [ACT_W-1:0] ACT_REVERSE = 3'd6;
  localparam logic [ACT_W-1:0] ACT_PALIN   = 3'd7;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FEW   = 2'd2;

endpackage

### src/stack_with_edit_operations.sv
// Top level of the stack with edit operations: control sequencer and the
// entry memory (one write port, two registered read ports).
// Depends on swe_pkg.
//
// Bounded LIFO stack of signed 32-bit words held in a 16-entry memory with one
// write port and two registered read ports. Each request on the slave
// stream names an action in tuser (push, pop, clear, duplicate, swap,
// remove value, reverse, palindrome query) with the word in tdata, and gets
// exactly one result on the master stream with status, count, top word,
// full, empty and palindrome flags. One request is worked at a time: a
// request runs its edit walk, then the top read and the palindrome walk,
// where duplicate reads the top word and writes its copy above it, swap and
// reverse read and then write each pair, remove reads every entry once, and
// the palindrome check compares pairs from both ends (n/2 pairs at most,
// ending at the first mismatch); the longest is a reverse followed by a full
// palindrome walk. A request that finishes while the previous result is
// still held on the master side waits until that result is taken.
// The walks are shaped by the single write port of the entry memory and
// the pairwise reads. A new request is taken while the previous result
// still waits on the master side. The capacity register is written
// through cfg_we/cfg_data; 0 acts as 1 and values above 16 act as 16.
module stack_with_edit_operations
  import swe_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CAP_W-1:0]    cfg_data,   // capacity
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [WORD_W-1:0]   s_tdata,    // [31:0] value
  input  logic [ACT_W-1:0]    s_tuser,    // [2:0] action
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OUT_W-1:0]    m_tdata     // [1:0] status, [6:2] count,
                                          // [38:7] top_value, [39] is_full,
                                          // [40] is_empty, [41] palindrome
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_DUP_RD  = 4'd1;
  localparam logic [3:0] ST_DUP_W   = 4'd2;
  localparam logic [3:0] ST_RV_RD   = 4'd3;
  localparam logic [3:0] ST_RV_W1   = 4'd4;
  localparam logic [3:0] ST_RV_W2   = 4'd5;
  localparam logic [3:0] ST_RM      = 4'd6;
  localparam logic [3:0] ST_TOP_RD  = 4'd7;
  localparam logic [3:0] ST_TOP_CAP = 4'd8;
  localparam logic [3:0] ST_PAL_RD  = 4'd9;
  localparam logic [3:0] ST_PAL_CMP = 4'd10;
  localparam logic [3:0] ST_OUT     = 4'd11;

  logic [WORD_W-1:0] mem [DEPTH];

  logic [3:0]        state;
  logic [CAP_W-1:0]  capacity;
  logic [CNT_W-1:0]  cnt;
  logic [STAT_W-1:0] stat;
  logic [WORD_W-1:0] val;
  logic [WORD_W-1:0] top;
  logic              pal;
  logic [IDX_W-1:0]  lo;
  logic [IDX_W-1:0]  hi;
  logic [WORD_W-1:0] lo_data;
  logic [CNT_W-1:0]  ptr;
  logic [CNT_W-1:0]  wr_ptr;
  logic              rm_v;
  logic [WORD_W-1:0] rd_a;
  logic [WORD_W-1:0] rd_b;

  logic [CNT_W-1:0]  eff_cap;
  logic              full;
  logic              accept;
  logic [IDX_W-1:0]  ra;
  logic              we;
  logic [IDX_W-1:0]  wa;
  logic [WORD_W-1:0] wd;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  cnt_m2;
  logic              pair_more;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign cnt_m1    = cnt - CNT_W'(1);
  assign cnt_m2    = cnt - CNT_W'(2);
  assign pair_more = (lo + IDX_W'(1)) < (hi - IDX_W'(1));

  always_comb begin
    if (capacity == '0) begin
      eff_cap = CNT_W'(1);
    end else if (capacity > CAP_W'(DEPTH)) begin
      eff_cap = CNT_W'(DEPTH);
    end else begin
      eff_cap = capacity;
    end
  end

  assign full = cnt >= eff_cap;

  always_comb begin
    case (state)
      ST_DUP_RD, ST_TOP_RD: ra = cnt_m1[IDX_W-1:0];
      ST_RM:                ra = ptr[IDX_W-1:0];
      default:              ra = lo;
    endcase
  end

  always_comb begin
    we = 1'b0;
    wa = cnt[IDX_W-1:0];
    wd = rd_a;
    case (state)
      ST_IDLE: begin
        we = accept && (s_tuser == ACT_PUSH) && !full;
        wd = s_tdata;
      end
      ST_DUP_W: begin
        we = 1'b1;
      end
      ST_RV_W1: begin
        we = 1'b1;
        wa = lo;
        wd = rd_b;
      end
      ST_RV_W2: begin
        we = 1'b1;
        wa = hi;
        wd = lo_data;
      end
      ST_RM: begin
        we = rm_v && (rd_a != val);
        wa = wr_ptr[IDX_W-1:0];
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a <= mem[ra];
    rd_b <= mem[hi];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_OUT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            val <= s_tdata;
            case (s_tuser)
              ACT_PUSH: begin
                state <= ST_TOP_RD;
                if (full) begin
                  stat <= STAT_FULL;
                end else begin
                  stat <= STAT_DONE;
                  cnt  <= cnt + CNT_W'(1);
                end
              end
              ACT_POP: begin
                state <= ST_TOP_RD;
                if (cnt == '0) begin
                  stat <= STAT_FEW;
                end else begin
                  stat <= STAT_DONE;
                  cnt  <= cnt_m1;
                end
              end
              ACT_CLEAR: begin
                stat  <= STAT_DONE;
                cnt   <= '0;
                state <= ST_TOP_RD;
              end
              ACT_DUP: begin
                if (cnt == '0) begin
                  stat  <= STAT_FEW;
                  state <= ST_TOP_RD;
                end else if (full) begin
                  stat  <= STAT_FULL;
                  state <= ST_TOP_RD;
                end else begin
                  stat  <= STAT_DONE;
                  state <= ST_DUP_RD;
                end
              end
              ACT_SWAP: begin
                if (cnt < CNT_W'(2)) begin
                  stat  <= STAT_FEW;
                  state <= ST_TOP_RD;
                end else begin
                  stat  <= STAT_DONE;
                  lo    <= cnt_m2[IDX_W-1:0];
                  hi    <= cnt_m1[IDX_W-1:0];
                  state <= ST_RV_RD;
                end
              end
              ACT_REMOVE: begin
                stat   <= STAT_DONE;
                ptr    <= '0;
                wr_ptr <= '0;
                rm_v   <= 1'b0;
                state  <= ST_RM;
              end
              ACT_REVERSE: begin
                stat <= STAT_DONE;
                if (cnt >= CNT_W'(2)) begin
                  lo    <= '0;
                  hi    <= cnt_m1[IDX_W-1:0];
                  state <= ST_RV_RD;
                end else begin
                  state <= ST_TOP_RD;
                end
              end
              default: begin
                stat  <= STAT_DONE;
                state <= ST_TOP_RD;
              end
            endcase
          end
        end
        ST_DUP_RD: begin
          state <= ST_DUP_W;
        end
        ST_DUP_W: begin
          cnt   <= cnt + CNT_W'(1);
          state <= ST_TOP_RD;
        end
        ST_RV_RD: begin
          state <= ST_RV_W1;
        end
        ST_RV_W1: begin
          lo_data <= rd_a;
          state   <= ST_RV_W2;
        end
        ST_RV_W2: begin
          lo <= lo + IDX_W'(1);
          hi <= hi - IDX_W'(1);
          state <= pair_more ? ST_RV_RD : ST_TOP_RD;
        end
        ST_RM: begin
          if (ptr < cnt) begin
            ptr <= ptr + CNT_W'(1);
          end
          rm_v <= ptr < cnt;
          if (rm_v && (rd_a != val)) begin
            wr_ptr <= wr_ptr + CNT_W'(1);
          end
          if (!(ptr < cnt) && !rm_v) begin
            cnt   <= wr_ptr;
            state <= ST_TOP_RD;
          end
        end
        ST_TOP_RD: begin
          state <= ST_TOP_CAP;
        end
        ST_TOP_CAP: begin
          top <= (cnt != '0) ? rd_a : '0;
          pal <= 1'b1;
          lo  <= '0;
          hi  <= cnt_m1[IDX_W-1:0];
          state <= (cnt >= CNT_W'(2)) ? ST_PAL_RD : ST_OUT;
        end
        ST_PAL_RD: begin
          state <= ST_PAL_CMP;
        end
        ST_PAL_CMP: begin
          if (rd_a != rd_b) begin
            pal   <= 1'b0;
            state <= ST_OUT;
          end else if (pair_more) begin
            lo    <= lo + IDX_W'(1);
            hi    <= hi - IDX_W'(1);
            state <= ST_PAL_RD;
          end else begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= OUT_W'({pal, (cnt == '0), full, top, cnt, stat});
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
